/* rtl/core/cpuu_pkg.sv */
// shared constants and types for the processor utilization block
package cpuu_pkg;

  localparam int unsigned MAX_CPUS  = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned TICK_W    = 64;
  localparam int unsigned USAGE_W   = 15;
  localparam int unsigned STATUS_W  = 2;

  // store address, wide enough for MAX_CPUS entries
  localparam int unsigned CPU_AW    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int unsigned IDX_EXT_W = 9;

  // 25600 = 25 << 10, the x25 is done as (x << 4) + (x << 3) + x
  localparam int unsigned SCALE_SHIFT = 10;
  localparam int unsigned ODD_W       = 5;
  localparam int unsigned UNIT_W      = TICK_W + ODD_W;

  // quotient bits and the low numerator bits fed into the divider
  localparam int unsigned QUO_W      = USAGE_W;
  localparam int unsigned REM_SHIFT  = QUO_W - SCALE_SHIFT;
  localparam int unsigned DIV_CNT_W  = $clog2(QUO_W);

  // counter terms: six busy ones first, then idle and iowait
  localparam int unsigned NUM_TERMS  = 8;
  localparam int unsigned TERM_W     = $clog2(NUM_TERMS);
  localparam int unsigned BUSY_LAST  = 5;

  localparam logic [USAGE_W-1:0]  FULL_SCALE  = USAGE_W'(25600);

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_TIME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLAMP   = 2'd2;

  typedef logic [TICK_W-1:0] tick_t;

  typedef struct packed {
    logic              en;
    logic [CPU_AW-1:0] addr;
    tick_t             busy;
    tick_t             total;
  } store_wr_t;

  typedef struct packed {
    tick_t busy;
    tick_t total;
  } store_rd_t;

endpackage

/* rtl/core/cpuu_sample_if.sv */
// input channel: processor index and eight cumulative tick counters
interface cpuu_sample_if;
  import cpuu_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  cpu_index;
  logic [TICK_W-1:0] user_ticks;
  logic [TICK_W-1:0] nice_ticks;
  logic [TICK_W-1:0] system_ticks;
  logic [TICK_W-1:0] idle_ticks;
  logic [TICK_W-1:0] iowait_ticks;
  logic [TICK_W-1:0] irq_ticks;
  logic [TICK_W-1:0] softirq_ticks;
  logic [TICK_W-1:0] steal_ticks;

  modport source (
    output valid, cpu_index, user_ticks, nice_ticks, system_ticks, idle_ticks,
           iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
    input  ready
  );

  modport sink (
    input  valid, cpu_index, user_ticks, nice_ticks, system_ticks, idle_ticks,
           iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
    output ready
  );
endinterface

/* rtl/core/cpuu_result_if.sv */
// output channel: echoed index, usage percentage and status
interface cpuu_result_if;
  import cpuu_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    result_index;
  logic [USAGE_W-1:0]  usage_q8;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, result_index, usage_q8, status,
    input  ready
  );

  modport sink (
    input  valid, result_index, usage_q8, status,
    output ready
  );
endinterface

/* rtl/core/cpuu_alu.sv */
// shared add / subtract unit with carry out
module cpuu_alu (
  input  logic [cpuu_pkg::UNIT_W-1:0] a,
  input  logic [cpuu_pkg::UNIT_W-1:0] b,
  input  logic                        sub,
  output logic [cpuu_pkg::UNIT_W-1:0] res,
  output logic                        carry
);
  import cpuu_pkg::*;

  logic [UNIT_W-1:0] b_op;

  // for subtract, carry set means a >= b
  assign b_op = sub ? ~b : b;
  assign {carry, res} = {1'b0, a} + {1'b0, b_op} + {{UNIT_W{1'b0}}, sub};
endmodule

/* rtl/core/cpuu_store.sv */
// per-processor previous busy and total sums
module cpuu_store (
  input  logic                         clk,
  input  logic                         rst,
  input  cpuu_pkg::store_wr_t          wr,
  input  logic [cpuu_pkg::CPU_AW-1:0]  rd_addr,
  output cpuu_pkg::store_rd_t          rd
);
  import cpuu_pkg::*;

  tick_t prev_busy  [MAX_CPUS];
  tick_t prev_total [MAX_CPUS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CPUS; i++) begin
        prev_busy[i]  <= '0;
        prev_total[i] <= '0;
      end
    end else if (wr.en) begin
      prev_busy[wr.addr]  <= wr.busy;
      prev_total[wr.addr] <= wr.total;
    end
  end

  assign rd.busy  = prev_busy[rd_addr];
  assign rd.total = prev_total[rd_addr];
endmodule

/* rtl/core/cpu_utilization_percent.sv */
// top level: per-processor busy percentage from cumulative tick counters
//
// sample channel: one beat carries a processor index and eight cumulative
//   tick counters; it is taken only while the sequencer is idle
// result channel: one beat per sample with the echoed index, the busy
//   percentage in q8 (25600 is 100 percent) and a status code
// one 69-bit add / subtract unit does all arithmetic, one operation a cycle:
//   the counter sums, the busy and total deltas, a compare, the x25 scale,
//   15 restoring divide steps, and the load of the output register
// a new sample is taken the cycle after the result is loaded; a zero time
//   delta or a clamp skips the multiply and divide, and an index beyond the
//   store goes straight to the output load without touching state
// the output register holds a finished result while the receiver stalls;
//   the next sample is still taken and worked on, and only the final load
//   waits until the held beat has gone
// reset clears the per-processor busy and total sums to zero, so the first
//   sample of a processor measures from time zero; no clearing pass is needed
module cpu_utilization_percent (
  input  logic         clk,
  input  logic         rst,
  cpuu_sample_if.sink  sample,
  cpuu_result_if.source result
);
  import cpuu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DBUSY,
    S_DTOT,
    S_CMP,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_FINISH
  } state_t;

  state_t                           state;
  logic [IDX_W-1:0]                 idx;
  logic [NUM_TERMS-1:0][TICK_W-1:0] terms;
  logic [TERM_W-1:0]                term_cnt;
  logic [UNIT_W-1:0]                acc;
  tick_t                            busy_sum;
  tick_t                            total_sum;
  tick_t                            dbusy;
  tick_t                            dtotal;
  tick_t                            rem;
  logic [QUO_W-1:0]                 nbits;
  logic [QUO_W-1:0]                 quo;
  logic [DIV_CNT_W-1:0]             div_cnt;
  logic [STATUS_W-1:0]              status_pend;

  logic                             out_valid;
  logic [IDX_W-1:0]                 out_index;
  logic [USAGE_W-1:0]               out_usage;
  logic [STATUS_W-1:0]              out_status;

  logic [UNIT_W-1:0]                alu_a;
  logic [UNIT_W-1:0]                alu_b;
  logic                             alu_sub;
  logic [UNIT_W-1:0]                alu_res;
  logic                             alu_carry;

  logic [IDX_EXT_W-1:0]             in_idx_ext;
  logic                             in_range;
  logic [IDX_EXT_W-1:0]             idx_ext;
  store_wr_t                        st_wr;
  store_rd_t                        st_rd;
  logic                             accept;

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = (state == S_IDLE);

  // range check on the incoming index, store address from the held one
  assign in_idx_ext = IDX_EXT_W'(sample.cpu_index);
  assign in_range   = in_idx_ext < IDX_EXT_W'(MAX_CPUS);
  assign idx_ext    = IDX_EXT_W'(idx);

  assign st_wr.en    = (state == S_DTOT);
  assign st_wr.addr  = idx_ext[CPU_AW-1:0];
  assign st_wr.busy  = busy_sum;
  assign st_wr.total = total_sum;

  cpuu_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (st_wr),
    .rd_addr (idx_ext[CPU_AW-1:0]),
    .rd      (st_rd)
  );

  // operand selection for the shared unit, one operation per state
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_SUM: begin
        alu_a = (term_cnt == '0) ? '0 : UNIT_W'(acc[TICK_W-1:0]);
        alu_b = UNIT_W'(terms[term_cnt]);
      end
      S_DBUSY: begin
        alu_a   = UNIT_W'(busy_sum);
        alu_b   = UNIT_W'(st_rd.busy);
        alu_sub = 1'b1;
      end
      S_DTOT: begin
        alu_a   = UNIT_W'(total_sum);
        alu_b   = UNIT_W'(st_rd.total);
        alu_sub = 1'b1;
      end
      // carry clear means busy delta above total delta
      S_CMP: begin
        alu_a   = UNIT_W'(dtotal);
        alu_b   = UNIT_W'(dbusy);
        alu_sub = 1'b1;
      end
      S_MUL1: begin
        alu_a = UNIT_W'({dbusy, 4'b0000});
        alu_b = UNIT_W'({dbusy, 3'b000});
      end
      S_MUL2: begin
        alu_a = acc;
        alu_b = UNIT_W'(dbusy);
      end
      // restoring step: shift in the next numerator bit, try the subtract
      S_DIV: begin
        alu_a   = UNIT_W'({rem, nbits[QUO_W-1]});
        alu_b   = UNIT_W'(dtotal);
        alu_sub = 1'b1;
      end
      S_IDLE, S_FINISH: begin
        alu_a = '0;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  cpuu_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in S_FINISH the load below decides the output register alone
      if (result.valid && result.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx      <= sample.cpu_index;
            terms    <= {sample.iowait_ticks, sample.idle_ticks, sample.steal_ticks,
                         sample.softirq_ticks, sample.irq_ticks, sample.system_ticks,
                         sample.nice_ticks, sample.user_ticks};
            term_cnt <= '0;
            if (in_range) begin
              state <= S_SUM;
            end else begin
              quo         <= '0;
              status_pend <= ST_NO_TIME;
              state       <= S_FINISH;
            end
          end
        end
        // sums wrap modulo 2^64
        S_SUM: begin
          acc <= UNIT_W'(alu_res[TICK_W-1:0]);
          if (term_cnt == TERM_W'(BUSY_LAST)) begin
            busy_sum <= alu_res[TICK_W-1:0];
          end
          if (term_cnt == TERM_W'(NUM_TERMS - 1)) begin
            total_sum <= alu_res[TICK_W-1:0];
            state     <= S_DBUSY;
          end else begin
            term_cnt <= term_cnt + 1'b1;
          end
        end
        S_DBUSY: begin
          dbusy <= alu_res[TICK_W-1:0];
          state <= S_DTOT;
        end
        S_DTOT: begin
          dtotal <= alu_res[TICK_W-1:0];
          state  <= S_CMP;
        end
        // zero elapsed time wins over the clamp
        S_CMP: begin
          priority if (dtotal == '0) begin
            quo         <= '0;
            status_pend <= ST_NO_TIME;
            state       <= S_FINISH;
          end else if (!alu_carry) begin
            quo         <= FULL_SCALE;
            status_pend <= ST_CLAMP;
            state       <= S_FINISH;
          end else begin
            status_pend <= ST_OK;
            state       <= S_MUL1;
          end
        end
        S_MUL1: begin
          acc   <= alu_res;
          state <= S_MUL2;
        end
        // numerator is (dbusy * 25) << 10; top part starts the remainder,
        // which is below dtotal since the quotient fits in 15 bits
        S_MUL2: begin
          rem     <= alu_res[UNIT_W-1:REM_SHIFT];
          nbits   <= {alu_res[REM_SHIFT-1:0], {SCALE_SHIFT{1'b0}}};
          quo     <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (alu_carry) begin
            rem <= alu_res[TICK_W-1:0];
          end else begin
            rem <= {rem[TICK_W-2:0], nbits[QUO_W-1]};
          end
          quo   <= {quo[QUO_W-2:0], alu_carry};
          nbits <= {nbits[QUO_W-2:0], 1'b0};
          if (div_cnt == DIV_CNT_W'(QUO_W - 1)) begin
            state <= S_FINISH;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        // wait here only while a previous beat is still held
        S_FINISH: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_index  <= idx;
            out_usage  <= quo;
            out_status <= status_pend;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.result_index = out_index;
  assign result.usage_q8     = out_usage;
  assign result.status       = out_status;

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < dtotal)
    else $error("divider remainder not below divisor");

  // divide never entered with zero elapsed time
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL2 |=> state == S_DIV && dtotal != '0)
    else $error("divide started with zero divisor");

  a_clamp_full: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_CLAMP |-> result.usage_q8 == FULL_SCALE)
    else $error("clamped result not full scale");

  a_no_time_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_NO_TIME |-> result.usage_q8 == '0)
    else $error("no elapsed time result not zero");

  a_usage_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.usage_q8 <= FULL_SCALE)
    else $error("usage above full scale");
endmodule

/* sim/cpuu_util_checker.sv */
// checker for the processor utilization block: predicts each result beat and compares it
`timescale 1ns / 100ps

module cpuu_util_checker
  import cpuu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cpuu_sample_if      smp,
  cpuu_result_if      res,
  output int unsigned fail_count,
  output int unsigned outstanding,
  output int unsigned results_seen,
  output int unsigned clamp_seen,
  output int unsigned no_time_seen
);

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [USAGE_W-1:0]  usage;
    logic [STATUS_W-1:0] status;
  } usage_result_t;

  // last busy and total sums per processor
  tick_t         busy_sum_mem  [MAX_CPUS];
  tick_t         total_sum_mem [MAX_CPUS];
  usage_result_t usage_due[$];

  int unsigned errs;
  int unsigned n_results;
  int unsigned n_clamp;
  int unsigned n_no_time;

  function automatic usage_result_t utilization_for_sample(
    input logic [IDX_W-1:0] idx,
    input tick_t            user_t,
    input tick_t            nice_t,
    input tick_t            system_t,
    input tick_t            idle_t,
    input tick_t            iowait_t,
    input tick_t            irq_t,
    input tick_t            softirq_t,
    input tick_t            steal_t
  );
    tick_t         busy;
    tick_t         total;
    tick_t         d_busy;
    tick_t         d_total;
    logic [127:0]  scaled;
    usage_result_t r;
    r.index = idx;
    if (idx >= MAX_CPUS) begin
      // no store behind this index: state untouched
      r.usage  = '0;
      r.status = ST_NO_TIME;
    end else begin
      busy    = user_t + nice_t + system_t + irq_t + softirq_t + steal_t;
      total   = busy + idle_t + iowait_t;
      d_busy  = busy - busy_sum_mem[idx];
      d_total = total - total_sum_mem[idx];
      busy_sum_mem[idx]  = busy;
      total_sum_mem[idx] = total;
      if (d_total == '0) begin
        r.usage  = '0;
        r.status = ST_NO_TIME;
      end else if (d_busy > d_total) begin
        r.usage  = FULL_SCALE;
        r.status = ST_CLAMP;
      end else begin
        scaled   = ({64'd0, d_busy} * 128'(FULL_SCALE)) / {64'd0, d_total};
        r.usage  = scaled[USAGE_W-1:0];
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    usage_result_t exp_r;
    if (rst) begin
      for (int i = 0; i < MAX_CPUS; i++) begin
        busy_sum_mem[i]  = '0;
        total_sum_mem[i] = '0;
      end
      usage_due.delete();
      errs      = 0;
      n_results = 0;
      n_clamp   = 0;
      n_no_time = 0;
    end else begin
      // result side first: a result can never belong to the sample of the same edge
      if (res.valid && res.ready) begin
        n_results++;
        if (res.status == ST_CLAMP)   n_clamp++;
        if (res.status == ST_NO_TIME) n_no_time++;
        if (usage_due.size() == 0) begin
          $error("result beat with no sample waiting: index %0d usage %0d status %0d",
                 res.result_index, res.usage_q8, res.status);
          errs++;
        end else begin
          exp_r = usage_due.pop_front();
          if (res.result_index !== exp_r.index) begin
            $error("result_index: expected %0d, got %0d", exp_r.index, res.result_index);
            errs++;
          end
          if (res.usage_q8 !== exp_r.usage) begin
            $error("usage_q8: expected %0d, got %0d", exp_r.usage, res.usage_q8);
            errs++;
          end
          if (res.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, res.status);
            errs++;
          end
        end
      end
      if (smp.valid && smp.ready) begin
        usage_due.push_back(utilization_for_sample(
          smp.cpu_index, smp.user_ticks, smp.nice_ticks, smp.system_ticks,
          smp.idle_ticks, smp.iowait_ticks, smp.irq_ticks, smp.softirq_ticks,
          smp.steal_ticks));
      end
    end
    fail_count   <= errs;
    outstanding  <= usage_due.size();
    results_seen <= n_results;
    clamp_seen   <= n_clamp;
    no_time_seen <= n_no_time;
  end

endmodule

/* sim/tb_cpu_utilization_percent.sv */
// testbench top for the processor utilization block: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_cpu_utilization_percent;
  import cpuu_pkg::*;

  // counter slots as they sit in a sample beat
  typedef enum int {
    T_USER, T_NICE, T_SYSTEM, T_IDLE, T_IOWAIT, T_IRQ, T_SOFTIRQ, T_STEAL, T_COUNT
  } tick_sel_t;

  localparam int unsigned RANDOM_PER_PHASE = 300;
  // a little more than the slowest sample-to-result path of the block
  localparam int unsigned DRAIN_CYCLES     = 40;

  logic clk = 1'b0;
  logic rst;

  cpuu_sample_if sample_ch ();
  cpuu_result_if result_ch ();

  // percent of cycles the sender holds back and the receiver stalls
  int unsigned idle_pct;
  int unsigned stall_pct;

  // cumulative counters as last sent for each processor, so that most
  // samples continue a believable sequence for that processor
  tick_t proc_ticks [MAX_CPUS][T_COUNT];
  int unsigned samples_sent;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned clamp_seen;
  int unsigned no_time_seen;

  cpu_utilization_percent u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  cpuu_util_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .smp          (sample_ch),
    .res          (result_ch),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .clamp_seen   (clamp_seen),
    .no_time_seen (no_time_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver flow control, redrawn every cycle
  always @(posedge clk) begin
    result_ch.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  // advance of one counter between two samples: mostly small, sometimes
  // zero, now and then large enough to make the divider work hard
  function automatic tick_t tick_step();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    return '0;
      2, 3, 4: return tick_t'($urandom_range(0, 1000));
      5, 6, 7: return tick_t'($urandom_range(0, 1 << 20));
      default: return {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
    endcase
  endfunction

  // one sample beat for a processor from its current counters; the sender
  // may hold back first, then the beat stays up until it is taken
  task automatic send_cpu(input int unsigned cpu);
    while ($urandom_range(0, 99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.cpu_index     <= IDX_W'(cpu);
    sample_ch.user_ticks    <= proc_ticks[cpu][T_USER];
    sample_ch.nice_ticks    <= proc_ticks[cpu][T_NICE];
    sample_ch.system_ticks  <= proc_ticks[cpu][T_SYSTEM];
    sample_ch.idle_ticks    <= proc_ticks[cpu][T_IDLE];
    sample_ch.iowait_ticks  <= proc_ticks[cpu][T_IOWAIT];
    sample_ch.irq_ticks     <= proc_ticks[cpu][T_IRQ];
    sample_ch.softirq_ticks <= proc_ticks[cpu][T_SOFTIRQ];
    sample_ch.steal_ticks   <= proc_ticks[cpu][T_STEAL];
    do @(posedge clk); while (!sample_ch.ready);
    samples_sent++;
  endtask

  // one random sample: mostly counters that move forward, with some noise
  // and some sequences that break the usual rules
  task automatic random_sample();
    int unsigned cpu;
    int unsigned shape;
    logic        idle_term;
    tick_t       step;
    cpu   = $urandom_range(0, MAX_CPUS - 1);
    shape = $urandom_range(0, 99);
    for (int k = 0; k < T_COUNT; k++) begin
      idle_term = (k == T_IDLE) || (k == T_IOWAIT);
      if (shape < 8) begin
        // noise: any value, often just below the wrap point
        proc_ticks[cpu][k] = $urandom_range(0, 1) ? {32'($urandom), 32'($urandom)}
                                                  : {32'hFFFF_FFFF, 32'($urandom)};
      end else if (shape < 14) begin
        // busy moves on while idle runs backward, mostly ends in a clamp
        if (idle_term) proc_ticks[cpu][k] -= tick_t'($urandom_range(0, 2000));
        else           proc_ticks[cpu][k] += tick_t'($urandom_range(0, 1000));
      end else if (shape >= 18) begin
        // shapes 14 to 17 leave the counters frozen: no elapsed time
        step = tick_step();
        if (shape < 28 && idle_term)                step = '0;  // fully busy
        if (shape >= 28 && shape < 38 && !idle_term) step = '0; // fully idle
        proc_ticks[cpu][k] += step;
      end
    end
    send_cpu(cpu);
  endtask

  initial begin : stimulus
    rst                     <= 1'b1;
    idle_pct                <= 12;
    stall_pct               <= 67;
    sample_ch.valid         <= 1'b0;
    sample_ch.cpu_index     <= '0;
    sample_ch.user_ticks    <= '0;
    sample_ch.nice_ticks    <= '0;
    sample_ch.system_ticks  <= '0;
    sample_ch.idle_ticks    <= '0;
    sample_ch.iowait_ticks  <= '0;
    sample_ch.irq_ticks     <= '0;
    sample_ch.softirq_ticks <= '0;
    sample_ch.steal_ticks   <= '0;
    samples_sent = 0;
    for (int c = 0; c < MAX_CPUS; c++) begin
      for (int k = 0; k < T_COUNT; k++) proc_ticks[c][k] = '0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // first sample of a processor that counted nothing yet: no elapsed time
    send_cpu(0);
    // 30 of 100 ticks busy since time zero
    proc_ticks[1][T_USER] = 64'd30;
    proc_ticks[1][T_IDLE] = 64'd70;
    send_cpu(1);
    // identical counters again: no elapsed time
    send_cpu(1);
    // busy up by 10 while iowait drops by 10: zero total delta beats the clamp
    proc_ticks[1][T_SYSTEM] += 64'd10;
    proc_ticks[1][T_IOWAIT] -= 64'd10;
    send_cpu(1);
    // busy up by 100 while idle drops by 50: busy delta above total delta
    proc_ticks[1][T_IRQ]  += 64'd100;
    proc_ticks[1][T_IDLE] -= 64'd50;
    send_cpu(1);
    // every counter at all ones, then back to zero: sums and deltas wrap
    for (int k = 0; k < T_COUNT; k++) proc_ticks[15][k] = '1;
    send_cpu(15);
    for (int k = 0; k < T_COUNT; k++) proc_ticks[15][k] = '0;
    send_cpu(15);
    // user counter wraps past the top between two samples
    proc_ticks[2][T_USER] = 64'hFFFF_FFFF_FFFF_FFFB;
    proc_ticks[2][T_IDLE] = 64'd1000;
    send_cpu(2);
    proc_ticks[2][T_USER] += 64'd10;
    proc_ticks[2][T_IDLE] += 64'd30;
    send_cpu(2);
    // all busy gives exactly full scale, all idle gives zero
    proc_ticks[3][T_STEAL] += 64'd500;
    send_cpu(3);
    proc_ticks[3][T_IDLE]  += 64'd500;
    send_cpu(3);
    // one third busy: the quotient truncates
    proc_ticks[5][T_SOFTIRQ] = 64'd1;
    proc_ticks[5][T_IOWAIT]  = 64'd2;
    send_cpu(5);
    // deltas near the full 64-bit range: the whole product matters
    proc_ticks[4][T_NICE] = 64'h8000_0000_0000_0000;
    proc_ticks[4][T_IDLE] = 64'h7FFF_FFFF_FFFF_FFFF;
    send_cpu(4);
    // one counter after another goes to all ones
    for (int k = 0; k < T_COUNT; k++) begin
      proc_ticks[6][k] = '1;
      send_cpu(6);
    end

    // ---- random part, three flow control phases ----
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          idle_pct  <= 12;
          stall_pct <= 67;
        end
        1: begin
          idle_pct  <= 67;
          stall_pct <= 12;
        end
        default: begin
          idle_pct  <= 0;
          stall_pct <= 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) random_sample();
    end
    sample_ch.valid <= 1'b0;

    // let the checker count the last sample, drain, then give a late stray
    // beat time to show up
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d samples over %0d processors, %0d results checked", samples_sent,
             MAX_CPUS, results_seen);
    $display("of those %0d clamped to full scale and %0d with no elapsed time", clamp_seen,
             no_time_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results still expected", outstanding);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/cpuu_pkg.sv
rtl/core/cpuu_sample_if.sv
rtl/core/cpuu_result_if.sv
rtl/core/cpuu_alu.sv
rtl/core/cpuu_store.sv
rtl/core/cpu_utilization_percent.sv
sim/cpuu_util_checker.sv
sim/tb_cpu_utilization_percent.sv
